[hdl/aes128_block_encrypt_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef AES128_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_CORE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/aes_pkg.sv]
// Package: AES constants, types and byte-level functions.
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int BlockBits = 128;
    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow  = 1'b1;

    typedef logic [BlockBits-1:0] block_t;

    typedef logic [7:0] sbox_table_t [256];

    localparam sbox_table_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Byte k of a block sits at bits 127-8k .. 120-8k.
    function automatic logic [7:0] get_byte(input block_t b, input int k);
        get_byte = b[BlockBits-1-8*k -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[BlockBits-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c+r)%4))];
        sub_shift = t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BlockBits-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        mix_columns = t;
    endfunction

    // Next round key from the previous one.
    function automatic block_t next_key(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

[hdl/aes_keyexp.sv]
// Key schedule: round keys that advance one step per stage, in step with the cipher stages.
module aes_keyexp
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  aes_pkg::block_t          key,
    output aes_pkg::block_t          round_key [aes_pkg::NumRounds+1]
);

    aes_pkg::block_t rk_reg [aes_pkg::NumRounds];

    // Each round key is registered once more than the one before it, so every
    // request meets the round keys of the key held when it was accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aes_pkg::NumRounds; i++)
                rk_reg[i] <= '0;
        end
        else
        begin
            rk_reg[0] <= aes_pkg::next_key(key, aes_pkg::RCON[0]);
            for (int i = 1; i < aes_pkg::NumRounds; i++)
                rk_reg[i] <= aes_pkg::next_key(rk_reg[i-1], aes_pkg::RCON[i]);
        end
    end

    always_comb
    begin
        round_key[0] = key;
        for (int i = 1; i <= aes_pkg::NumRounds; i++)
            round_key[i] = rk_reg[i-1];
    end

endmodule

[hdl/aes_round.sv]
// One registered cipher round stage.
module aes_round
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            last,
    input  logic            in_vld,
    input  aes_pkg::block_t in_state,
    input  aes_pkg::block_t rkey,
    output logic            out_vld,
    output aes_pkg::block_t out_state
);

    aes_pkg::block_t ss;
    aes_pkg::block_t state_next;
    aes_pkg::block_t state_reg;
    logic            vld_reg;

    always_comb
    begin
        ss = aes_pkg::sub_shift(in_state);
        state_next = (last ? ss : aes_pkg::mix_columns(ss)) ^ rkey;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign out_vld   = vld_reg;
    assign out_state = state_reg;

endmodule

[hdl/aes128_block_encrypt_core.sv]
// Top level: AES-128 encryption pipeline with key registers.
//
// Usage:
//   Write the key through the config channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data): index 0 is key_high, index 1 is key_low.
//   cfg_ready is always high. Round keys travel down the pipeline with the
//   data, so a new key applies from the very next request on.
//   Issue a request by raising start with plain_high/plain_low; busy is
//   always low, so one request may enter every cycle.
//   Pipeline: eleven register stages (one key-add stage, ten round stages);
//   done rises once a request has passed the key-add register and all ten round
//   registers. Throughput: one block per cycle, set by the fully unrolled round
//   stages.
//   Each result shows on cipher_high/cipher_low for one cycle with done high;
//   the receiver cannot stall, so nothing is held back.
//   Reset clears the key to zero, the round keys, and all valid bits.
module aes128_block_encrypt_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] plain_high,
    input  logic [63:0] plain_low,
    output logic        done,
    output logic [63:0] cipher_high,
    output logic [63:0] cipher_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]     key_high_reg;
    logic [63:0]     key_low_reg;
    aes_pkg::block_t round_key [aes_pkg::NumRounds+1];
    aes_pkg::block_t st [aes_pkg::NumRounds+1];
    logic            vld [aes_pkg::NumRounds+1];
    aes_pkg::block_t st0_reg;
    logic            vld0_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Hold the key; a write lands when valid meets ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                aes_pkg::CfgKeyHigh: key_high_reg <= cfg_data;
                aes_pkg::CfgKeyLow:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_keyexp u_keyexp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .round_key (round_key)
    );

    // Initial key add stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else
            vld0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        st0_reg <= {plain_high, plain_low} ^ round_key[0];
    end

    assign st[0]  = st0_reg;
    assign vld[0] = vld0_reg;

    // Advance through ten round stages; the last skips MixColumns.
    for (genvar r = 1; r <= aes_pkg::NumRounds; r++)
    begin : g_round
        aes_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .last      (r == aes_pkg::NumRounds),
            .in_vld    (vld[r-1]),
            .in_state  (st[r-1]),
            .rkey      (round_key[r]),
            .out_vld   (vld[r]),
            .out_state (st[r])
        );
    end

    assign done        = vld[aes_pkg::NumRounds];
    assign cipher_high = st[aes_pkg::NumRounds][127:64];
    assign cipher_low  = st[aes_pkg::NumRounds][63:0];

endmodule

[hdl/aes128_block_encrypt_core_chk.sv]
// Port-level checker for the encryption core, bound to the top level.
`include "aes128_block_encrypt_core_macros.svh"
module aes128_block_encrypt_core_chk
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);

    logic req;

    assign req = start && !busy;

    `AES_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")
    `AES_ASSERT_IMPL(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "config not ready")
    `AES_ASSERT_IMPL(a_latency, clk, rst_n, $past(req, 11) && $past(rst_n, 11), done, "no done")
    `AES_ASSERT_IMPL(a_no_spurious, clk, rst_n, done && $past(rst_n, 11), $past(req, 11), "stray")

endmodule

bind aes128_block_encrypt_core aes128_block_encrypt_core_chk u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);
